FILE: rtl/core/blinn_phong_pixel_shader_macros.svh
// Assertion helpers used by the shader RTL.
`ifndef BLINN_PHONG_PIXEL_SHADER_MACROS_SVH
`define BLINN_PHONG_PIXEL_SHADER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BPS_AP_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BPS_AP_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bps_pkg.sv
package bps_pkg;

  localparam int VEC_W    = 16;
  localparam int COEF_W   = 9;
  localparam int CHAN_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int EXP_W    = 7;
  localparam int LDIR_W   = 3 * VEC_W;
  localparam int LCOL_W   = 3 * CHAN_W;

  localparam int DEF_VECTOR_FRACTION_BITS = 14;

  // dot product datapath
  localparam int RL_W     = VEC_W + 1;
  localparam int H_W      = VEC_W + 2;
  localparam int LNP_W    = RL_W + VEC_W;
  localparam int DNP_W    = H_W + VEC_W;
  localparam int HHP_W    = 2 * VEC_W + 1;
  localparam int DLN_W    = LNP_W + 2;
  localparam int DOT_W    = DNP_W + 2;
  localparam int HH_W     = HHP_W + 1;
  localparam int ROOT_W   = (HH_W + 1) / 2;

  // one multiply stage per possible exponent step
  localparam int EXP_STAGES = 2 ** EXP_W - 1;

  // color datapath
  localparam int T_W      = COEF_W + 10;
  localparam int A_W      = T_W + COEF_W;
  localparam int B_W      = A_W + CHAN_W;
  localparam int C_SHIFT  = 16;
  localparam int C_W      = B_W + GAIN_W - C_SHIFT;
  localparam int O_SHIFT  = 24;
  localparam int O_W      = C_W + GAIN_W - O_SHIFT;

  // register port
  localparam int PADDR_W  = 6;
  localparam int PDATA_W  = 64;
  localparam int IDX_LSB  = 3;
  localparam int IDX_W    = PADDR_W - IDX_LSB;

  typedef enum logic [IDX_W-1:0] {
    REG_LIGHT_DIR   = 3'd0,
    REG_LIGHT_COLOR = 3'd1,
    REG_LIGHT_INT   = 3'd2,
    REG_SPEC_EXP    = 3'd3,
    REG_AMP_GAIN    = 3'd4
  } reg_idx_e;

  localparam logic [LDIR_W-1:0] LDIR_RST = '0;
  localparam logic [LCOL_W-1:0] LCOL_RST = '0;
  localparam logic [GAIN_W-1:0] LINT_RST = 16'd256;
  localparam logic [EXP_W-1:0]  SEXP_RST = 7'd10;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd640;

  typedef struct packed {
    logic [COEF_W-1:0]        diffuse;
    logic [COEF_W-1:0]        specular;
    logic [2:0][COEF_W-1:0]   refl;
  } mat_t;

endpackage

FILE: rtl/core/bps_nh_unit.sv
module bps_nh_unit #(
  parameter int FRAC_BITS = bps_pkg::DEF_VECTOR_FRACTION_BITS
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [bps_pkg::HH_W-1:0]          hh_i,
  input  logic signed [bps_pkg::DOT_W-1:0]  dot_i,
  output logic [FRAC_BITS:0]                nh_o
);
  import bps_pkg::*;

  localparam int SQ_W  = HH_W + 1;
  localparam int NQ    = FRAC_BITS + 1;
  localparam int DIV_W = (FRAC_BITS + ROOT_W + 1 > DOT_W - 1) ? FRAC_BITS + ROOT_W + 1
                                                             : DOT_W - 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // integer square root, one result bit per stage
  logic [SQ_W-1:0]         sx_in   [ROOT_W];
  logic [SQ_W-1:0]         sr_in   [ROOT_W];
  logic signed [DOT_W-1:0] sdot_in [ROOT_W];
  logic [SQ_W-1:0]         sx_q    [ROOT_W];
  logic [SQ_W-1:0]         sr_q    [ROOT_W];
  logic signed [DOT_W-1:0] sdot_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_root
    localparam logic [SQ_W-1:0] RBIT = SQ_W'(1) << (2 * (ROOT_W - 1 - s));
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] sx_d;
    logic [SQ_W-1:0] sr_d;

    if (s == 0) begin : g_first
      assign sx_in[s]   = SQ_W'(hh_i);
      assign sr_in[s]   = '0;
      assign sdot_in[s] = dot_i;
    end else begin : g_next
      assign sx_in[s]   = sx_q[s-1];
      assign sr_in[s]   = sr_q[s-1];
      assign sdot_in[s] = sdot_q[s-1];
    end

    always_comb begin
      trial = sr_in[s] + RBIT;
      if (sx_in[s] >= trial) begin
        sx_d = sx_in[s] - trial;
        sr_d = (sr_in[s] >> 1) + RBIT;
      end else begin
        sx_d = sx_in[s];
        sr_d = sr_in[s] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sx_q[s]   <= sx_d;
        sr_q[s]   <= sr_d;
        sdot_q[s] <= sdot_in[s];
      end
    end
  end

  // range check: quotient of 2.0 or more saturates
  logic [ROOT_W-1:0] hlen;
  logic              pos_d;
  logic [DIV_W-1:0]  rm_d;
  logic              ovf_d;
  logic [ROOT_W-1:0] dv0_q;
  logic [DIV_W-1:0]  rm0_q;
  logic              ovf0_q;
  logic              pos0_q;

  assign hlen = sr_q[ROOT_W-1][ROOT_W-1:0];

  always_comb begin
    pos_d = !sdot_q[ROOT_W-1][DOT_W-1] && (sdot_q[ROOT_W-1] != '0);
    rm_d  = pos_d ? DIV_W'(sdot_q[ROOT_W-1][DOT_W-2:0]) : '0;
    ovf_d = rm_d >= (DIV_W'(hlen) << NQ);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv0_q  <= hlen;
      rm0_q  <= rm_d;
      ovf0_q <= ovf_d;
      pos0_q <= pos_d;
    end
  end

  // restoring divide, one quotient bit per stage
  logic [ROOT_W-1:0]  dv_in  [NQ];
  logic [DIV_W-1:0]   rm_in  [NQ];
  logic [FRAC_BITS:0] qq_in  [NQ];
  logic               ovf_in [NQ];
  logic               pos_in [NQ];
  logic [ROOT_W-1:0]  dv_q   [NQ];
  logic [DIV_W-1:0]   rm_q   [NQ];
  logic [FRAC_BITS:0] qq_q   [NQ];
  logic               ovf_q  [NQ];
  logic               pos_q  [NQ];

  for (genvar j = 0; j < NQ; j++) begin : g_div
    logic [DIV_W-1:0]   sub;
    logic [DIV_W-1:0]   rm_d2;
    logic [FRAC_BITS:0] qq_d;

    if (j == 0) begin : g_first
      assign dv_in[j]  = dv0_q;
      assign rm_in[j]  = rm0_q;
      assign qq_in[j]  = '0;
      assign ovf_in[j] = ovf0_q;
      assign pos_in[j] = pos0_q;
    end else begin : g_next
      assign dv_in[j]  = dv_q[j-1];
      assign rm_in[j]  = rm_q[j-1];
      assign qq_in[j]  = qq_q[j-1];
      assign ovf_in[j] = ovf_q[j-1];
      assign pos_in[j] = pos_q[j-1];
    end

    always_comb begin
      sub = DIV_W'(dv_in[j]) << (FRAC_BITS - j);
      if (rm_in[j] >= sub) begin
        rm_d2 = rm_in[j] - sub;
        qq_d  = {qq_in[j][FRAC_BITS-1:0], 1'b1};
      end else begin
        rm_d2 = rm_in[j];
        qq_d  = {qq_in[j][FRAC_BITS-1:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j]  <= dv_in[j];
        rm_q[j]  <= rm_d2;
        qq_q[j]  <= qq_d;
        ovf_q[j] <= ovf_in[j];
        pos_q[j] <= pos_in[j];
      end
    end
  end

  logic [FRAC_BITS:0] nh_d;
  logic [FRAC_BITS:0] nh_q;

  always_comb begin
    if (!pos_q[NQ-1] || (dv_q[NQ-1] == '0)) begin
      nh_d = '0;
    end else if (ovf_q[NQ-1] || (qq_q[NQ-1] > ONE)) begin
      nh_d = ONE;
    end else begin
      nh_d = qq_q[NQ-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nh_q <= nh_d;
    end
  end

  assign nh_o = nh_q;

endmodule

FILE: rtl/core/blinn_phong_pixel_shader.sv
// Blinn-Phong pixel shader, one directional light, fully pipelined.
// Throughput: one pixel beat per cycle while the output side keeps up.
// Most of the path from input beat to output valid is the 127-stage specular power chain
// plus the root and divide stages.
// Reset (rst_ni low, async) empties the pipe and output buffer and loads register defaults.
`include "blinn_phong_pixel_shader_macros.svh"

module blinn_phong_pixel_shader #(
  parameter int VECTOR_FRACTION_BITS = bps_pkg::DEF_VECTOR_FRACTION_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bps_pkg::PADDR_W-1:0]         paddr,
  input  logic [bps_pkg::PDATA_W-1:0]         pwdata,
  output logic [bps_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [bps_pkg::VEC_W-1:0]    normal_x_i,
  input  logic signed [bps_pkg::VEC_W-1:0]    normal_y_i,
  input  logic signed [bps_pkg::VEC_W-1:0]    normal_z_i,
  input  logic signed [bps_pkg::VEC_W-1:0]    view_x_i,
  input  logic signed [bps_pkg::VEC_W-1:0]    view_y_i,
  input  logic signed [bps_pkg::VEC_W-1:0]    view_z_i,
  input  logic [bps_pkg::COEF_W-1:0]          diffuse_coeff_i,
  input  logic [bps_pkg::COEF_W-1:0]          specular_coeff_i,
  input  logic [bps_pkg::COEF_W-1:0]          reflect_red_i,
  input  logic [bps_pkg::COEF_W-1:0]          reflect_green_i,
  input  logic [bps_pkg::COEF_W-1:0]          reflect_blue_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bps_pkg::CHAN_W-1:0]          red_out_o,
  output logic [bps_pkg::CHAN_W-1:0]          green_out_o,
  output logic [bps_pkg::CHAN_W-1:0]          blue_out_o
);
  import bps_pkg::*;

  localparam int F       = VECTOR_FRACTION_BITS;
  localparam int LN_W    = F + 1;
  localparam int TP_W    = COEF_W + LN_W;
  localparam int NH_LAT  = ROOT_W + F + 3;
  localparam int MAT_W   = $bits(mat_t);
  localparam int SIDE_W  = LN_W + 1 + MAT_W;
  localparam int PS_W    = LN_W + MAT_W;
  localparam int PIPE_D  = 3 + NH_LAT + EXP_STAGES + 7;
  localparam int LAST    = PIPE_D - 1;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // ---------------- configuration registers ----------------
  logic [LDIR_W-1:0] ldir_q;
  logic [LCOL_W-1:0] lcol_q;
  logic [GAIN_W-1:0] lint_q;
  logic [EXP_W-1:0]  sexp_q;
  logic [GAIN_W-1:0] gain_q;
  logic              cfg_we;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:IDX_LSB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ldir_q <= LDIR_RST;
      lcol_q <= LCOL_RST;
      lint_q <= LINT_RST;
      sexp_q <= SEXP_RST;
      gain_q <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LIGHT_DIR:   ldir_q <= pwdata[LDIR_W-1:0];
        REG_LIGHT_COLOR: lcol_q <= pwdata[LCOL_W-1:0];
        REG_LIGHT_INT:   lint_q <= pwdata[GAIN_W-1:0];
        REG_SPEC_EXP:    sexp_q <= pwdata[EXP_W-1:0];
        REG_AMP_GAIN:    gain_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LIGHT_DIR:   prdata = PDATA_W'(ldir_q);
      REG_LIGHT_COLOR: prdata = PDATA_W'(lcol_q);
      REG_LIGHT_INT:   prdata = PDATA_W'(lint_q);
      REG_SPEC_EXP:    prdata = PDATA_W'(sexp_q);
      REG_AMP_GAIN:    prdata = PDATA_W'(gain_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic              pipe_en;
  logic [PIPE_D-1:0] vld_q;
  logic [1:0]        cnt_q;
  logic              wr_q;
  logic              rd_q;
  logic              push;
  logic              pop;

  assign pipe_en    = (cnt_q != 2'd2);
  assign in_ready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[PIPE_D-2:0], in_valid_i};
    end
  end

  // ---------------- S1: light negate, half vector ----------------
  logic signed [VEC_W-1:0] nin [3];
  logic signed [VEC_W-1:0] vin [3];
  mat_t                    min_w;
  logic signed [RL_W-1:0]  rl_d [3];
  logic signed [H_W-1:0]   h_d  [3];
  logic signed [VEC_W-1:0] n1_q [3];
  logic signed [RL_W-1:0]  rl1_q[3];
  logic signed [H_W-1:0]   h1_q [3];
  mat_t                    m1_q;

  assign nin[0] = normal_x_i;
  assign nin[1] = normal_y_i;
  assign nin[2] = normal_z_i;
  assign vin[0] = view_x_i;
  assign vin[1] = view_y_i;
  assign vin[2] = view_z_i;
  assign min_w.diffuse  = diffuse_coeff_i;
  assign min_w.specular = specular_coeff_i;
  assign min_w.refl[0]  = reflect_red_i;
  assign min_w.refl[1]  = reflect_green_i;
  assign min_w.refl[2]  = reflect_blue_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rl_d[k] = RL_W'(0) - RL_W'($signed(ldir_q[k*VEC_W +: VEC_W]));
      h_d[k]  = H_W'(rl_d[k]) - H_W'(vin[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        n1_q[k]  <= nin[k];
        rl1_q[k] <= rl_d[k];
        h1_q[k]  <= h_d[k];
      end
      m1_q <= min_w;
    end
  end

  // ---------------- S2: products ----------------
  logic signed [LNP_W-1:0] lnp_d [3];
  logic signed [DNP_W-1:0] dnp_d [3];
  logic signed [2*H_W-1:0] hsq_d [3];
  logic signed [LNP_W-1:0] lnp_q [3];
  logic signed [DNP_W-1:0] dnp_q [3];
  logic [HHP_W-1:0]        hhp_q [3];
  mat_t                    m2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lnp_d[k] = rl1_q[k] * n1_q[k];
      dnp_d[k] = h1_q[k] * n1_q[k];
      hsq_d[k] = h1_q[k] * h1_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        lnp_q[k] <= lnp_d[k];
        dnp_q[k] <= dnp_d[k];
        hhp_q[k] <= hsq_d[k][HHP_W-1:0];
      end
      m2_q <= m1_q;
    end
  end

  // ---------------- S3: sums, diffuse term ----------------
  logic signed [DLN_W-1:0] dln_d;
  logic [DLN_W-1:0]        lnsh;
  logic signed [DOT_W-1:0] dnh3_d;
  logic [HH_W-1:0]         hh3_d;
  logic [F:0]              ln3_d;
  logic signed [DOT_W-1:0] dnh3_q;
  logic [HH_W-1:0]         hh3_q;
  logic [F:0]              ln3_q;
  logic                    hz3_q;
  mat_t                    m3_q;

  always_comb begin
    dln_d  = DLN_W'(lnp_q[0]) + DLN_W'(lnp_q[1]) + DLN_W'(lnp_q[2]);
    dnh3_d = DOT_W'(dnp_q[0]) + DOT_W'(dnp_q[1]) + DOT_W'(dnp_q[2]);
    hh3_d  = HH_W'(hhp_q[0]) + HH_W'(hhp_q[1]) + HH_W'(hhp_q[2]);
    lnsh   = $unsigned(dln_d) >> F;
    if (dln_d[DLN_W-1] || (dln_d == '0)) begin
      ln3_d = '0;
    end else if (lnsh > DLN_W'(ONE)) begin
      ln3_d = ONE;
    end else begin
      ln3_d = lnsh[F:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dnh3_q <= dnh3_d;
      hh3_q  <= hh3_d;
      ln3_q  <= ln3_d;
      hz3_q  <= (hh3_d == '0);
      m3_q   <= m2_q;
    end
  end

  // ---------------- N.H via root and divide ----------------
  logic [F:0]        nh_u;
  logic [SIDE_W-1:0] sd_q [NH_LAT];

  bps_nh_unit #(
    .FRAC_BITS (F)
  ) u_nh (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .hh_i  (hh3_q),
    .dot_i (dnh3_q),
    .nh_o  (nh_u)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sd_q[0] <= {ln3_q, hz3_q, m3_q};
      for (int k = 1; k < NH_LAT; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // ---------------- specular power, one multiply per stage ----------------
  logic [F:0]      pp_in [EXP_STAGES];
  logic [F:0]      pn_in [EXP_STAGES];
  logic [PS_W-1:0] ps_in [EXP_STAGES];
  logic [F:0]      pp_q  [EXP_STAGES];
  logic [F:0]      pn_q  [EXP_STAGES];
  logic [PS_W-1:0] ps_q  [EXP_STAGES];
  logic [F:0]      p0;

  assign p0 = sd_q[NH_LAT-1][MAT_W] ? '0 : ONE;

  for (genvar i = 0; i < EXP_STAGES; i++) begin : g_pow
    localparam logic [EXP_W-1:0] STEP = EXP_W'(i);
    logic [2*F+1:0] prod;
    logic [F:0]     pp_d;

    if (i == 0) begin : g_first
      assign pp_in[i] = p0;
      assign pn_in[i] = nh_u;
      assign ps_in[i] = {sd_q[NH_LAT-1][SIDE_W-1 -: LN_W], sd_q[NH_LAT-1][MAT_W-1:0]};
    end else begin : g_next
      assign pp_in[i] = pp_q[i-1];
      assign pn_in[i] = pn_q[i-1];
      assign ps_in[i] = ps_q[i-1];
    end

    always_comb begin
      prod = pp_in[i] * pn_in[i];
      pp_d = (STEP < sexp_q) ? prod[2*F:F] : pp_in[i];
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        pp_q[i] <= pp_d;
        pn_q[i] <= pn_in[i];
        ps_q[i] <= ps_in[i];
      end
    end
  end

  // ---------------- T1/T2: weighted sum ----------------
  mat_t              mf;
  logic [F:0]        lnf;
  logic [TP_W-1:0]   td_q;
  logic [TP_W-1:0]   ts_q;
  mat_t              mt1_q;
  logic [TP_W:0]     tsum;
  logic [T_W-1:0]    t_q;
  logic [COEF_W-1:0] rt2_q [3];

  assign mf  = mat_t'(ps_q[EXP_STAGES-1][MAT_W-1:0]);
  assign lnf = ps_q[EXP_STAGES-1][PS_W-1 -: LN_W];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      td_q  <= TP_W'(mf.diffuse * lnf);
      ts_q  <= TP_W'(mf.specular * pp_q[EXP_STAGES-1]);
      mt1_q <= mf;
    end
  end

  assign tsum = (TP_W + 1)'(td_q) + (TP_W + 1)'(ts_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      t_q <= tsum[TP_W:F-8];
      for (int k = 0; k < 3; k++) begin
        rt2_q[k] <= mt1_q.refl[k];
      end
    end
  end

  // ---------------- C1..C5: per-channel scaling ----------------
  logic [A_W-1:0]           a_q [3];
  logic [B_W-1:0]           b_q [3];
  logic [B_W+GAIN_W-1:0]    cw  [3];
  logic [C_W-1:0]           c_q [3];
  logic [C_W+GAIN_W-1:0]    ow  [3];
  logic [O_W-1:0]           o_q [3];
  logic [CHAN_W-1:0]        s_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cw[k] = b_q[k] * lint_q;
      ow[k] = c_q[k] * gain_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= A_W'(t_q * rt2_q[k]);
        b_q[k] <= B_W'(a_q[k] * lcol_q[k*CHAN_W +: CHAN_W]);
        c_q[k] <= cw[k][B_W+GAIN_W-1:C_SHIFT];
        o_q[k] <= ow[k][C_W+GAIN_W-1:O_SHIFT];
        // saturate at full scale
        s_q[k] <= (o_q[k][O_W-1:CHAN_W] != '0) ? {CHAN_W{1'b1}} : o_q[k][CHAN_W-1:0];
      end
    end
  end

  // ---------------- two-entry output buffer ----------------
  logic [LCOL_W-1:0] fq_q [2];
  logic [LCOL_W-1:0] fq_head;

  assign push        = pipe_en && vld_q[LAST];
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign fq_head     = fq_q[rd_q];
  assign red_out_o   = fq_head[CHAN_W-1:0];
  assign green_out_o = fq_head[2*CHAN_W-1:CHAN_W];
  assign blue_out_o  = fq_head[3*CHAN_W-1:2*CHAN_W];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fq_q[wr_q] <= {s_q[2], s_q[1], s_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // ---------------- checks ----------------
  `BPS_AP_NOW(a_buf_bound, 1'b1, cnt_q != 2'd3, "output buffer overflow")
  `BPS_AP_NEXT(a_stall_hold, (!pipe_en && vld_q[LAST]), vld_q[LAST], "stalled beat lost")
  `BPS_AP_NEXT(a_front_take, (in_valid_i && in_ready_o), vld_q[0], "accepted beat dropped")

endmodule
